[src/mot_pkg.sv]
// ----------------------------------------------------------------------------
// mot_pkg: shared types, constants and fixed-point helpers
// Q8.24 rounding and saturation, network sizes and the divider handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package mot_pkg;

    localparam int W_LEN = 6;                       // window taps
    localparam int HU    = 2;                       // hidden units
    localparam int NW    = HU * W_LEN;              // hidden weights
    localparam int NWB   = (NW > 1) ? $clog2(NW) : 1;
    localparam int HB    = (HU > 1) ? $clog2(HU) : 1;
    localparam int KB    = (W_LEN > 1) ? $clog2(W_LEN) : 1;

    localparam logic [31:0] RATE_RST = 32'd6710886;  // 0.4 in Q8.24

    localparam logic [1:0] OP_TRAIN   = 2'd0;
    localparam logic [1:0] OP_PREDICT = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    // round to nearest (add half, floor shift by 24)
    function automatic logic signed [39:0] rnd24(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd8388608;
        return s[63:24];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) r = 32'sh7fffffff;
        else if (v < -42'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
        return sat32(42'(rnd24(p)));
    endfunction

endpackage

`default_nettype wire

[src/mot_mul.sv]
// ----------------------------------------------------------------------------
// mot_mul: shared signed multiplier
// 32x32 signed multiply, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_mul (
    input  wire                 i_clk,
    input  wire  signed [31:0]  i_a,
    input  wire  signed [31:0]  i_b,
    output logic signed [63:0]  o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[src/mot_div.sv]
// ----------------------------------------------------------------------------
// mot_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mot_div (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  mot_pkg::t_div_req i_req,
    output mot_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_div;
    logic [64:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[63]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? 64'(w_trial - {1'b0, r_div}) : w_trial[63:0];
                r_quo <= {r_quo[62:0], w_ge};
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

[src/mlp_online_trainer.sv]
// ----------------------------------------------------------------------------
// mlp_online_trainer: online 6-2-1 perceptron predictor and trainer
// Forward pass, base-2 sigmoid, backpropagation and adaptive hidden rate on
// one shared multiplier and one shared divider under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_axis): tuser carries op, tdata the window samples,
//    target, weight index and weight value. One transfer is one step.
//  - Output stream (m_axis): one result transfer per input transfer:
//    prediction, error, squared error and the hidden rate after the step.
//  - Config channel (cfg): writes output_rate; always ready, write it only
//    while the block is idle.
//  - Sequencing: every multiply has an issue phase and a consume phase;
//    every sigmoid and the rate update take one divide, after which the
//    quotient is picked up. A load goes straight to the result; train
//    adds the weight and rate updates to the predict pass, and skips the
//    rate divide when the divisor is zero. The divider dominates.
//  - One item at a time: s_axis tready is low from accept until the result
//    transfer completes; a stalled receiver holds the result in place.
//    After the result transfer the block returns to idle for the next accept.
//  - Reset (synchronous, active low) clears all weights and thresholds,
//    sets hidden and output rates to 0.4 and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_online_trainer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [95:0] sample0..sample5, [111:96] target, [116:112] weight_index,
    // [148:117] weight_value, [151:149] zero
    input  wire  [151:0] i_s_axis_tdata,
    // [1:0] op
    input  wire  [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // [31:0] prediction, [63:32] error, [94:64] squared_error,
    // [125:95] adapted_rate, [127:126] zero
    output logic [127:0] o_m_axis_tdata,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [24:0]  i_cfg_data
);

    localparam int W_LEN = mot_pkg::W_LEN;
    localparam int HU    = mot_pkg::HU;
    localparam int NW    = mot_pkg::NW;
    localparam int NWB   = mot_pkg::NWB;
    localparam int HB    = mot_pkg::HB;
    localparam int KB    = mot_pkg::KB;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_HACC = 5'd1;   // x*w accumulate
    localparam logic [4:0] S_HSUM = 5'd2;   // z, split |z|
    localparam logic [4:0] S_SIGP = 5'd3;   // 2^f polynomial, start divide
    localparam logic [4:0] S_SIGD = 5'd4;   // wait sigmoid quotient
    localparam logic [4:0] S_OACC = 5'd5;
    localparam logic [4:0] S_YSUM = 5'd6;
    localparam logic [4:0] S_SQ   = 5'd7;
    localparam logic [4:0] S_AE   = 5'd8;
    localparam logic [4:0] S_OW   = 5'd9;
    localparam logic [4:0] S_OTH  = 5'd10;
    localparam logic [4:0] S_D    = 5'd11;
    localparam logic [4:0] S_G1   = 5'd12;
    localparam logic [4:0] S_G2   = 5'd13;
    localparam logic [4:0] S_R    = 5'd14;
    localparam logic [4:0] S_HW   = 5'd15;
    localparam logic [4:0] S_HT   = 5'd16;
    localparam logic [4:0] S_G2S  = 5'd17;
    localparam logic [4:0] S_SA   = 5'd18;
    localparam logic [4:0] S_DD   = 5'd19;
    localparam logic [4:0] S_SB   = 5'd20;
    localparam logic [4:0] S_YY   = 5'd21;
    localparam logic [4:0] S_DEN  = 5'd22;
    localparam logic [4:0] S_RD   = 5'd23;
    localparam logic [4:0] S_OUT  = 5'd24;

    // control
    logic [4:0]    r_state;
    logic          r_ph;        // 0: multiply issued, 1: product ready
    logic [HB-1:0] r_h;
    logic [KB-1:0] r_k;
    logic [1:0]    r_op;

    // network state
    logic signed [31:0] r_hw [NW];
    logic signed [31:0] r_ht [HU];
    logic signed [31:0] r_ow [HU];
    logic signed [31:0] r_oth;
    logic signed [31:0] r_hrate;
    logic [24:0]        r_orate;

    // per-item working values
    logic signed [31:0] r_x [W_LEN];
    logic signed [31:0] r_tgt;
    logic signed [63:0] r_acc;
    logic               r_zneg;
    logic [4:0]         r_n;
    logic [23:0]        r_f;
    logic signed [31:0] r_hid [HU];
    logic signed [31:0] r_d [HU];
    logic signed [31:0] r_g [HU];
    logic signed [31:0] r_t1;
    logic signed [31:0] r_t2;
    logic signed [31:0] r_rr;
    logic signed [31:0] r_ae;
    logic signed [31:0] r_f1;
    logic signed [39:0] r_sa;
    logic signed [39:0] r_sb;
    logic signed [31:0] r_y;
    logic signed [31:0] r_e;
    logic [30:0]        r_sq;

    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_prod;
    logic [NWB-1:0]     w_widx;
    logic signed [31:0] w_z;
    logic [31:0]        w_zabs;
    logic signed [31:0] w_y;
    logic signed [31:0] w_e;
    logic [31:0]        w_p;
    logic [63:0]        w_sden;
    logic signed [39:0] w_rnd;
    logic signed [31:0] w_mq;
    logic signed [31:0] w_av;
    mot_pkg::t_div_req  w_dreq;
    mot_pkg::t_div_rsp  w_drsp;
    logic [4:0]         w_idx;
    logic signed [31:0] w_wval;

    assign w_widx = NWB'(int'(r_h) * W_LEN + int'(r_k));
    assign w_rnd  = mot_pkg::rnd24(w_prod);
    assign w_mq   = mot_pkg::mulq(w_prod);
    assign w_idx  = i_s_axis_tdata[116:112];
    assign w_wval = i_s_axis_tdata[148:117];

    // hidden pre-activation and its magnitude split
    assign w_z    = mot_pkg::sat32(42'(mot_pkg::rnd24(r_acc)) - 42'(r_ht[r_h]));
    assign w_zabs = w_z[31] ? 32'(33'd0 - {w_z[31], w_z}) : w_z;

    assign w_y = mot_pkg::sat32(42'(mot_pkg::rnd24(r_acc)) - 42'(r_oth));
    assign w_e = mot_pkg::sat32(42'(w_y) - 42'(r_tgt));

    // P = 2^30 + (f*(21*2^24 + 11f)) >> 23, D = (P << n) + 2^30
    assign w_p    = 32'h4000_0000 + {1'b0, w_prod[53:23]};
    assign w_sden = ({32'd0, w_p} << r_n) + 64'h4000_0000;
    assign w_av   = mot_pkg::sat32(42'(r_sa));

    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = 64'h0040_0000_0000_0000 + (w_sden >> 1);
        w_dreq.divisor  = w_sden;
        if (r_state == S_SIGP && r_ph) begin
            w_dreq.start = 1'b1;
        end else if (r_state == S_DEN) begin
            w_dreq.start    = r_ph && (w_rnd > 40'sd0);
            w_dreq.dividend = {6'd0, w_av, 26'd0};
            w_dreq.divisor  = 64'(w_rnd);
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_HACC: begin w_ma = r_x[r_k];           w_mb = r_hw[w_widx]; end
            S_SIGP: begin
                w_ma = {8'd0, r_f};
                w_mb = 32'd352321536 + {5'd0, r_f, 3'd0} + {7'd0, r_f, 1'b0}
                       + {8'd0, r_f};
            end
            S_OACC: begin w_ma = r_hid[r_h];         w_mb = r_ow[r_h]; end
            S_SQ:   begin w_ma = r_e;                w_mb = r_e; end
            S_AE:   begin w_ma = {7'd0, r_orate};    w_mb = r_e; end
            S_OW:   begin w_ma = r_ae;               w_mb = r_hid[r_h]; end
            S_D:    begin w_ma = r_hid[r_h];
                          w_mb = 32'sh0100_0000 - r_hid[r_h]; end
            S_G1:   begin w_ma = r_d[r_h];           w_mb = r_ow[r_h]; end
            S_G2:   begin w_ma = r_t1;               w_mb = r_e; end
            S_R:    begin w_ma = r_hrate;            w_mb = r_g[r_h]; end
            S_HW:   begin w_ma = r_x[r_k];           w_mb = r_rr; end
            S_G2S:  begin w_ma = r_g[r_h];           w_mb = r_g[r_h]; end
            S_SA:   begin w_ma = r_t1;               w_mb = r_d[r_h]; end
            S_DD:   begin w_ma = r_d[r_h];           w_mb = r_d[r_h]; end
            S_SB:   begin w_ma = r_t1;               w_mb = r_t2; end
            S_YY:   begin w_ma = r_y;                w_mb = r_y; end
            S_DEN:  begin w_ma = mot_pkg::sat32(42'(r_sb)); w_mb = r_f1; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    mot_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    mot_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_h     <= '0;
            r_k     <= '0;
            r_op    <= mot_pkg::OP_TRAIN;
            for (int i = 0; i < NW; i++) r_hw[i] <= '0;
            for (int i = 0; i < HU; i++) begin
                r_ht[i] <= '0;
                r_ow[i] <= '0;
            end
            r_oth   <= '0;
            r_hrate <= mot_pkg::RATE_RST;
            r_orate <= mot_pkg::RATE_RST[24:0];
        end else begin
            if (i_cfg_valid) r_orate <= i_cfg_data;

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op <= i_s_axis_tuser;
                        for (int k = 0; k < W_LEN; k++) begin
                            if (k < 6) begin
                                r_x[k] <= {{6{i_s_axis_tdata[16*k+15]}},
                                           i_s_axis_tdata[16*k +: 16], 10'd0};
                            end else begin
                                r_x[k] <= '0;
                            end
                        end
                        r_tgt <= {{6{i_s_axis_tdata[111]}}, i_s_axis_tdata[111:96], 10'd0};
                        r_h   <= '0;
                        r_k   <= '0;
                        r_ph  <= 1'b0;
                        r_acc <= '0;
                        if (i_s_axis_tuser == mot_pkg::OP_LOAD) begin
                            // weight write; out-of-range index writes nothing
                            r_y  <= '0;
                            r_e  <= '0;
                            r_sq <= '0;
                            if (w_idx < 5'(NW)) begin
                                r_hw[NWB'(w_idx)] <= w_wval;
                            end else if (w_idx < 5'(NW + HU)) begin
                                r_ht[HB'(w_idx - 5'(NW))] <= w_wval;
                            end else if (w_idx < 5'(NW + 2 * HU)) begin
                                r_ow[HB'(w_idx - 5'(NW + HU))] <= w_wval;
                            end else if (w_idx == 5'(NW + 2 * HU)) begin
                                r_oth <= w_wval;
                            end else if (w_idx == 5'(NW + 2 * HU + 1)) begin
                                r_hrate <= w_wval;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_HACC;
                        end
                    end
                end
                S_HACC: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc <= r_acc + w_prod;
                        if (r_k == KB'(W_LEN - 1)) begin
                            r_k     <= '0;
                            r_state <= S_HSUM;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_HSUM: begin
                    r_zneg  <= w_z[31];
                    r_n     <= (w_zabs[31:24] > 8'd30) ? 5'd30 : w_zabs[28:24];
                    r_f     <= w_zabs[23:0];
                    r_state <= S_SIGP;
                end
                S_SIGP: begin
                    r_ph <= ~r_ph;
                    if (r_ph) r_state <= S_SIGD;
                end
                S_SIGD: begin
                    if (w_drsp.done) begin
                        r_hid[r_h] <= r_zneg ? w_drsp.quot[31:0]
                                             : 32'sh0100_0000 - w_drsp.quot[31:0];
                        r_acc <= '0;
                        if (r_h == HB'(HU - 1)) begin
                            r_h     <= '0;
                            r_state <= S_OACC;
                        end else begin
                            r_h     <= r_h + 1'b1;
                            r_state <= S_HACC;
                        end
                    end
                end
                S_OACC: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc <= r_acc + w_prod;
                        if (r_h == HB'(HU - 1)) begin
                            r_h     <= '0;
                            r_state <= S_YSUM;
                        end else begin
                            r_h <= r_h + 1'b1;
                        end
                    end
                end
                S_YSUM: begin
                    r_y     <= w_y;
                    r_e     <= w_e;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_sq <= (w_rnd > 40'sd2147483647) ? 31'h7fff_ffff : w_rnd[30:0];
                        r_state <= (r_op == mot_pkg::OP_TRAIN) ? S_AE : S_OUT;
                    end
                end
                S_AE: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_ae    <= w_mq;
                        r_state <= S_OW;
                    end
                end
                S_OW: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_ow[r_h] <= mot_pkg::sat32(42'(r_ow[r_h]) - 42'(w_rnd));
                        if (r_h == HB'(HU - 1)) begin
                            r_h     <= '0;
                            r_state <= S_OTH;
                        end else begin
                            r_h <= r_h + 1'b1;
                        end
                    end
                end
                S_OTH: begin
                    r_oth   <= mot_pkg::sat32(42'(r_oth) + 42'(r_ae));
                    r_state <= S_D;
                end
                S_D: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_d[r_h] <= w_rnd[31:0];
                        r_state  <= S_G1;
                    end
                end
                S_G1: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_t1    <= w_mq;
                        r_state <= S_G2;
                    end
                end
                S_G2: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_g[r_h] <= w_mq;
                        r_state  <= S_R;
                    end
                end
                S_R: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_rr    <= w_mq;
                        r_k     <= '0;
                        r_state <= S_HW;
                    end
                end
                S_HW: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_hw[w_widx] <= mot_pkg::sat32(42'(r_hw[w_widx]) - 42'(w_rnd));
                        if (r_k == KB'(W_LEN - 1)) begin
                            r_k     <= '0;
                            r_state <= S_HT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_HT: begin
                    r_ht[r_h] <= mot_pkg::sat32(42'(r_ht[r_h]) + 42'(r_rr));
                    r_sa      <= '0;
                    r_sb      <= '0;
                    if (r_h == HB'(HU - 1)) begin
                        r_h     <= '0;
                        r_state <= S_G2S;
                    end else begin
                        r_h     <= r_h + 1'b1;
                        r_state <= S_D;
                    end
                end
                S_G2S: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_t1    <= w_mq;
                        r_state <= S_SA;
                    end
                end
                S_SA: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_sa    <= r_sa + 40'(w_mq);
                        r_state <= S_DD;
                    end
                end
                S_DD: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_t2    <= w_mq;
                        r_state <= S_SB;
                    end
                end
                S_SB: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_sb <= r_sb + 40'(w_mq);
                        if (r_h == HB'(HU - 1)) begin
                            r_h     <= '0;
                            r_state <= S_YY;
                        end else begin
                            r_h     <= r_h + 1'b1;
                            r_state <= S_G2S;
                        end
                    end
                end
                S_YY: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_f1    <= mot_pkg::sat32(42'sd16777216 + 42'(w_mq));
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_ph <= ~r_ph;
                    // zero divisor keeps the old rate
                    if (r_ph) r_state <= (w_rnd > 40'sd0) ? S_RD : S_OUT;
                end
                S_RD: begin
                    if (w_drsp.done) begin
                        r_hrate <= (w_drsp.quot > 64'd2147483647) ? 32'sh7fff_ffff
                                                                   : w_drsp.quot[31:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tdata  = {2'b00, (r_hrate[31] ? 31'd0 : r_hrate[30:0]), r_sq, r_e, r_y};

`ifndef SYNTH
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input accepted while a result is pending");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.busy |-> (r_state == S_SIGD || r_state == S_RD))
        else $error("divider busy outside a divide wait");

    a_sig_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGD && w_drsp.done) |=> (r_state == S_HACC || r_state == S_OACC))
        else $error("sigmoid done did not advance the sequencer");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_m_axis_tready) |=> (r_state == S_IDLE))
        else $error("result transfer did not return to idle");
`endif

endmodule

`default_nettype wire
